// ===== sv/gne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_pkg
// Shared constants, register codes and the square root chain item type for
// the group norm engine.
// ----------------------------------------------------------------------------
package gne_pkg;

    localparam int MAX_GROUP_DEFAULT   = 64;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam int VALUE_BITS = 16;
    localparam int SUM_BITS   = 37;
    localparam int NORM_BITS  = 22;
    localparam int SQRT_STEPS = (SUM_BITS + 1) / 2;

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [NORM_BITS-1:0] NORM_MAX = {NORM_BITS{1'b1}};

    localparam logic [1:0] KIND_SUP = 2'd0;
    localparam logic [1:0] KIND_L1  = 2'd1;
    localparam logic [1:0] KIND_L2  = 2'd2;

    localparam logic REG_NORM_KIND = 1'b0;
    localparam logic REG_REPEAT    = 1'b1;

    typedef struct packed {
        logic [SUM_BITS-1:0]  rem;
        logic [SUM_BITS-1:0]  root;
        logic [NORM_BITS-1:0] plain;
        logic                 is_l2;
        logic                 ovf;
    } gne_item_t;

endpackage

// ===== sv/gne_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_accum
// Per-group accumulator: folds each sample magnitude into the running max,
// sum or sum of squares and launches the group into the square root chain.
// ----------------------------------------------------------------------------
module gne_accum #(
    parameter int MAX_GROUP   = gne_pkg::MAX_GROUP_DEFAULT,
    parameter int SAMPLE_BITS = gne_pkg::SAMPLE_BITS_DEFAULT,
    parameter int CW          = $clog2(MAX_GROUP + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic signed [gne_pkg::VALUE_BITS-1:0] value,
    input  logic                              group_end,
    input  logic [1:0]                        norm_kind,
    input  logic                              repeat_en,
    output logic                              head_valid,
    output gne_pkg::gne_item_t                head_item,
    output logic [CW-1:0]                     head_copies
);
    import gne_pkg::*;

    localparam int XW = (SAMPLE_BITS > VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;
    localparam int SQ = 2 * SAMPLE_BITS;
    localparam int AW = ((SQ > SUM_BITS) ? SQ : SUM_BITS) + 1;

    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;

    logic signed [XW-1:0]   value_ext;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ-1:0]          square;
    logic [AW-1:0]          addend;
    logic [AW-1:0]          total;
    logic [SUM_BITS-1:0]    sum_new;
    logic                   full;

    always_comb
    begin
        value_ext = XW'(value);
        sample    = value_ext[SAMPLE_BITS-1:0];
        mag       = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        square    = SQ'(mag) * SQ'(mag);
        if (norm_kind == KIND_L1)
            addend = AW'(mag);
        else
            addend = AW'(square);
        total = AW'(sum_reg) + addend;
        case (norm_kind)
            KIND_SUP: sum_new = (SUM_BITS'(mag) > sum_reg) ? SUM_BITS'(mag) : sum_reg;
            default:  sum_new = (total > AW'(SUM_MAX)) ? SUM_MAX : total[SUM_BITS-1:0];
        endcase
        full       = (count_reg >= CW'(MAX_GROUP));
        count_next = full ? count_reg : count_reg + 1'b1;
        ovf_next   = ovf_reg | full;
        sum_next   = sum_new;

        head_valid      = accept & group_end;
        head_item.rem   = sum_new;
        head_item.root  = '0;
        head_item.plain = (sum_new > SUM_BITS'(NORM_MAX)) ? NORM_MAX : sum_new[NORM_BITS-1:0];
        head_item.is_l2 = !((norm_kind == KIND_SUP) || (norm_kind == KIND_L1));
        head_item.ovf   = ovf_next;
        head_copies     = repeat_en ? count_next : CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (group_end)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

// ===== sv/gne_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_sqrt_cell
// One step of the bit-by-bit integer square root; cells are chained so that
// each resolves one root bit and hands the group on to its neighbor.
// ----------------------------------------------------------------------------
module gne_sqrt_cell #(
    parameter int MAX_GROUP = gne_pkg::MAX_GROUP_DEFAULT,
    parameter int STEP      = 0,
    parameter int CW        = $clog2(MAX_GROUP + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  gne_pkg::gne_item_t in_item,
    input  logic [CW-1:0]      in_copies,
    output logic               out_valid,
    output gne_pkg::gne_item_t out_item,
    output logic [CW-1:0]      out_copies
);
    import gne_pkg::*;

    localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (2 * (SQRT_STEPS - 1 - STEP));

    logic                valid_reg;
    gne_item_t           item_reg, item_next;
    logic [CW-1:0]       copies_reg;
    logic [SUM_BITS-1:0] trial;

    always_comb
    begin
        item_next = in_item;
        trial     = in_item.root + BIT;
        if (in_item.rem >= trial)
        begin
            item_next.rem  = in_item.rem - trial;
            item_next.root = (in_item.root >> 1) + BIT;
        end
        else
        begin
            item_next.root = in_item.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg   <= item_next;
            copies_reg <= in_copies;
        end
    end

    assign out_valid  = valid_reg;
    assign out_item   = item_reg;
    assign out_copies = copies_reg;

endmodule

// ===== sv/gne_repeat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_repeat
// Output register: picks the group norm off the chain tail and issues it
// once per copy, marking the final beat.
// ----------------------------------------------------------------------------
module gne_repeat #(
    parameter int MAX_GROUP = gne_pkg::MAX_GROUP_DEFAULT,
    parameter int CW        = $clog2(MAX_GROUP + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tail_valid,
    input  gne_pkg::gne_item_t            tail_item,
    input  logic [CW-1:0]                 tail_copies,
    output logic                          advance,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gne_pkg::NORM_BITS-1:0] norm_value,
    output logic                          last,
    output logic                          group_too_long
);
    import gne_pkg::*;

    logic                 valid_reg;
    logic [CW-1:0]        left_reg;
    logic [NORM_BITS-1:0] norm_reg;
    logic                 ovf_reg;
    logic                 final_beat;
    logic                 load;

    always_comb
    begin
        final_beat = (left_reg == CW'(1));
        load       = tail_valid && (!valid_reg || (out_ready && final_beat));
        advance    = !tail_valid || load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            left_reg  <= tail_copies;
        end
        else if (valid_reg && out_ready)
        begin
            if (final_beat)
                valid_reg <= 1'b0;
            else
                left_reg <= left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            norm_reg <= tail_item.is_l2 ? tail_item.root[NORM_BITS-1:0] : tail_item.plain;
            ovf_reg  <= tail_item.ovf;
        end
    end

    assign out_valid      = valid_reg;
    assign norm_value     = norm_reg;
    assign last           = final_beat;
    assign group_too_long = ovf_reg;

endmodule

// ===== sv/group_norm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_norm_engine
// Streaming per-group sup, L1 or L2 norm with optional per-element repeat.
// ----------------------------------------------------------------------------
// One element is accepted per cycle. The element that closes a group enters
// a chain of 19 square root cells, one root bit per cell, and its result
// beats then leave through the output register; the next group accumulates
// meanwhile and several groups may be in the chain at once. With repeat set
// a group gives one beat per element (at most MAX_GROUP). Input stalls only
// while the chain tail waits on the output register. Registers: 0 norm_kind
// (0 sup, 1 L1, 2 L2), 1 repeat_per_element.
module group_norm_engine #(
    parameter int MAX_GROUP   = gne_pkg::MAX_GROUP_DEFAULT,
    parameter int SAMPLE_BITS = gne_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gne_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [gne_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [gne_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [gne_pkg::VALUE_BITS-1:0] value,
    input  logic                               group_end,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gne_pkg::NORM_BITS-1:0]      norm_value,
    output logic                               last,
    output logic                               group_too_long
);
    import gne_pkg::*;

    localparam int CW = $clog2(MAX_GROUP + 1);

    logic [1:0] norm_kind_reg;
    logic       repeat_reg;
    logic       cfg_write;
    logic       reg_sel;
    logic       advance;
    logic       accept;

    logic          chain_valid  [0:SQRT_STEPS];
    gne_item_t     chain_item   [0:SQRT_STEPS];
    logic [CW-1:0] chain_copies [0:SQRT_STEPS];

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_sel == REG_NORM_KIND) ? PDATA_BITS'(norm_kind_reg)
                                                  : PDATA_BITS'(repeat_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_kind_reg <= KIND_L2;
            repeat_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_NORM_KIND)
                norm_kind_reg <= pwdata[1:0];
            else
                repeat_reg <= pwdata[0];
        end
    end

    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    gne_accum #(
        .MAX_GROUP   (MAX_GROUP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .value       (value),
        .group_end   (group_end),
        .norm_kind   (norm_kind_reg),
        .repeat_en   (repeat_reg),
        .head_valid  (chain_valid[0]),
        .head_item   (chain_item[0]),
        .head_copies (chain_copies[0])
    );

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_cell
        gne_sqrt_cell #(
            .MAX_GROUP (MAX_GROUP),
            .STEP      (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .in_valid   (chain_valid[k]),
            .in_item    (chain_item[k]),
            .in_copies  (chain_copies[k]),
            .out_valid  (chain_valid[k+1]),
            .out_item   (chain_item[k+1]),
            .out_copies (chain_copies[k+1])
        );
    end

    gne_repeat #(
        .MAX_GROUP (MAX_GROUP)
    ) u_repeat (
        .clk            (clk),
        .rst_n          (rst_n),
        .tail_valid     (chain_valid[SQRT_STEPS]),
        .tail_item      (chain_item[SQRT_STEPS]),
        .tail_copies    (chain_copies[SQRT_STEPS]),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .norm_value     (norm_value),
        .last           (last),
        .group_too_long (group_too_long)
    );

    a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[SQRT_STEPS] && chain_item[SQRT_STEPS].is_l2
        |-> chain_item[SQRT_STEPS].rem <= (chain_item[SQRT_STEPS].root << 1))
        else $error("square root remainder exceeds twice the root");

    a_copies_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[SQRT_STEPS] |-> chain_copies[SQRT_STEPS] != '0)
        else $error("group reached output with zero copies");

    a_more_copies: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("group dropped before its last beat");

endmodule

// ===== test/gne_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gne_checker
// Watches the register port and both streams of the group norm engine, folds
// every accepted element into its own copy of the group accumulator, queues
// the norm beats each closed group owes, and matches result beats in order.
// ----------------------------------------------------------------------------
module gne_checker #(
    parameter int MAX_GROUP = gne_pkg::MAX_GROUP_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gne_pkg::PADDR_BITS-1:0]        paddr,
    input  logic [gne_pkg::PDATA_BITS-1:0]        pwdata,
    input  logic                                  pready,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic signed [gne_pkg::VALUE_BITS-1:0] value,
    input  logic                                  group_end,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [gne_pkg::NORM_BITS-1:0]         norm_value,
    input  logic                                  last,
    input  logic                                  group_too_long,
    output int                                    fail_count,
    output int                                    pending
);
    import gne_pkg::*;

    typedef struct packed {
        logic [NORM_BITS-1:0] norm;
        logic                 closing;
        logic                 too_long;
    } norm_beat_t;

    norm_beat_t          owed_norms[$];
    logic [1:0]          kind;
    logic                repeat_on;
    logic [SUM_BITS-1:0] group_acc;
    logic [6:0]          group_count;
    logic                group_overflow;
    int                  mismatches;

    function automatic logic [VALUE_BITS:0] magnitude(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS:0] wide;
        wide = {v[VALUE_BITS-1], v};
        if (v[VALUE_BITS-1])
            wide = -wide;
        return wide;
    endfunction

    function automatic logic [63:0] floor_root(input logic [SUM_BITS-1:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        for (int b = 19; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= {27'd0, n})
                root = trial;
        end
        return root;
    endfunction

    task automatic fold_sample(input logic [VALUE_BITS-1:0] v, input logic closes);
        logic [63:0] mag;
        logic [63:0] acc;
        logic [63:0] result;
        int          copies;
        norm_beat_t  beat;
        mag = 64'(magnitude(v));
        acc = 64'(group_acc);
        if (kind == KIND_SUP)
        begin
            if (mag > acc)
                acc = mag;
        end
        else if (kind == KIND_L1)
            acc = acc + mag;
        else
            acc = acc + mag * mag;
        if (acc > SUM_MAX)
            acc = SUM_MAX;
        group_acc = acc[SUM_BITS-1:0];
        if (group_count >= MAX_GROUP)
            group_overflow = 1'b1;
        else
            group_count = group_count + 7'd1;
        if (closes)
        begin
            if (kind == KIND_SUP || kind == KIND_L1)
                result = acc;
            else
                result = floor_root(group_acc);
            if (result > NORM_MAX)
                result = NORM_MAX;
            copies = repeat_on ? int'(group_count) : 1;
            for (int k = 0; k < copies; k++)
            begin
                beat.norm     = result[NORM_BITS-1:0];
                beat.closing  = (k == copies - 1);
                beat.too_long = group_overflow;
                owed_norms.push_back(beat);
            end
            group_acc      = '0;
            group_count    = '0;
            group_overflow = 1'b0;
        end
    endtask

    task automatic compare_beat();
        norm_beat_t want;
        if (owed_norms.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unowed beat norm=%0d last=%0b too_long=%0b",
                         $time, norm_value, last, group_too_long);
        end
        else
        begin
            want = owed_norms.pop_front();
            if (norm_value !== want.norm || last !== want.closing
                    || group_too_long !== want.too_long)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: beat mismatch exp norm=%0d last=%0b too_long=%0b, got %0d %0b %0b",
                             $time, want.norm, want.closing, want.too_long,
                             norm_value, last, group_too_long);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind           = KIND_L2;
            repeat_on      = 1'b0;
            group_acc      = '0;
            group_count    = '0;
            group_overflow = 1'b0;
            mismatches     = 0;
            owed_norms.delete();
            fail_count     <= 0;
            pending        <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_NORM_KIND, 2'b00})
                    kind = pwdata[1:0];
                else if (paddr == {REG_REPEAT, 2'b00})
                    repeat_on = pwdata[0];
            end
            if (out_valid && out_ready)
                compare_beat();
            if (in_valid && in_ready)
                fold_sample(value, group_end);
            fail_count <= mismatches;
            pending    <= owed_norms.size();
        end
    end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Group norm engine test: directed edge groups, then random groups over every
// norm kind and repeat setting, a long output hold-off, and a gap-free finish.
// The checker predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import gne_pkg::*;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         HOLD_CYCLES = 200;
    localparam int         QUIET_LIMIT = 2000;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [PADDR_BITS-1:0]  paddr          = '0;
    logic [PDATA_BITS-1:0]  pwdata         = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;
    logic                   in_valid       = 1'b0;
    logic                   in_ready;
    logic signed [VALUE_BITS-1:0] value    = '0;
    logic                   group_end      = 1'b0;
    logic                   out_valid;
    logic                   out_ready      = 1'b0;
    logic [NORM_BITS-1:0]   norm_value;
    logic                   last;
    logic                   group_too_long;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    bit idle_off      = 1'b0;
    bit hold_request  = 1'b0;

    group_norm_engine i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .group_end      (group_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .norm_value     (norm_value),
        .last           (last),
        .group_too_long (group_too_long)
    );

    gne_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .group_end      (group_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .norm_value     (norm_value),
        .last           (last),
        .group_too_long (group_too_long),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!idle_off && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic reg_idx, input logic [PDATA_BITS-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_element(input logic [VALUE_BITS-1:0] v, input logic closes);
        @(negedge clk);
        in_valid  <= 1'b1;
        value     <= v;
        group_end <= closes;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (!idle_off && $urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 10))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
    endtask

    // hold input, wait out owed beats and the pipeline
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_sample(input bit heavy);
        int roll;
        roll = $urandom_range(0, heavy ? 3 : 15);
        case (roll)
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h8001;
            3:       return heavy ? 16'h8000 : 16'h0000;
            4:       return 16'hffff;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    function automatic int pick_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(56, 72);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_group(input int len, input bit heavy);
        for (int k = 0; k < len; k++)
            send_element(pick_sample(heavy), k == len - 1);
    endtask

    initial
    begin
        int         target;
        logic [1:0] kind_sel;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_element(16'h7fff, 1'b1);
        send_element(16'h8000, 1'b1);
        send_element(16'h0000, 1'b1);
        send_element(16'd3, 1'b0);
        send_element(-16'sd4, 1'b1);
        drain();
        write_reg(REG_NORM_KIND, {30'd0, KIND_SUP});
        send_element(16'h8000, 1'b0);
        send_element(16'd5, 1'b0);
        send_element(16'h7fff, 1'b1);
        drain();
        write_reg(REG_NORM_KIND, {30'd0, KIND_L1});
        write_reg(REG_REPEAT, 32'd1);
        send_element(16'h8000, 1'b0);
        send_element(16'h8000, 1'b0);
        send_element(16'd100, 1'b1);
        drain();
        write_reg(REG_NORM_KIND, {30'd0, KIND_SPARE});
        send_element(16'd3, 1'b0);
        send_element(-16'sd4, 1'b1);
        drain();
        write_reg(REG_NORM_KIND, {30'd0, KIND_L1});
        write_reg(REG_REPEAT, 32'd0);
        send_element(16'd10, 1'b0);
        send_element(-16'sd20, 1'b0);
        drain();
        write_reg(REG_NORM_KIND, {30'd0, KIND_SUP});
        send_element(16'd7, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0:       kind_sel = KIND_SUP;
                1:       kind_sel = KIND_L1;
                2:       kind_sel = KIND_L2;
                3:       kind_sel = KIND_SPARE;
                default: kind_sel = 2'($urandom_range(0, 3));
            endcase
            write_reg(REG_NORM_KIND, {30'd0, kind_sel});
            write_reg(REG_REPEAT, (p < 4) ? p % 2 : $urandom_range(0, 1));
            if (p == 0)
            begin
                send_group(64, 1'b0);
                send_group(65, 1'b0);
            end
            if (p == 1 || p == 2)
                send_group($urandom_range(130, 134), 1'b1);
            target = items_sent + 8;
            while (items_sent < target)
                send_group(pick_length(), 1'b0);
        end

        drain();
        write_reg(REG_NORM_KIND, {30'd0, KIND_L2});
        write_reg(REG_REPEAT, 32'd0);
        hold_request = 1'b1;
        for (int g = 0; g < 30; g++)
            send_group(1, 1'b0);

        drain();
        write_reg(REG_NORM_KIND, {30'd0, KIND_L1});
        write_reg(REG_REPEAT, 32'd1);
        idle_off = 1'b1;
        target = items_sent + 30;
        while (items_sent < target)
            send_group(pick_length(), 1'b0);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
